// File: hw/rtl/bss_pkg.sv
package bss_pkg;

  // Default number of entries in the store.
  localparam int DEFAULT_CAPACITY = 32;

  // Field widths of the items.
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Operation codes carried on the input tuser.
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_RD,
    S_READ_LOAD,
    S_APPLY,
    S_FINISH
  } state_t;

endpackage

// File: hw/rtl/bounded_set_store_core.sv
// Bounded set store: a packed list of up to CAPACITY distinct 32-bit values
// kept in insertion order.
// Input channel s_*: one item is one operation. s_tuser carries the mode
// (add, remove, member query, read at index, clear); s_tdata carries the value
// and the read index. Output channel m_*: one result item per input item with
// status, was_member, read_value and the entry count after the operation.
// The entries live in a single-port-write, single-port-read memory, and one
// shared comparator walks it one entry at a time, with a read state and a
// compare state per entry, since the memory read is registered. A remove
// also moves each entry behind the removed one down one place, with a read
// state and a write state per entry. A read passes S_READ_RD and S_READ_LOAD
// (skipped on an empty store); clear and unused modes go straight to S_FINISH.
// One item is in work at a time; s_tready is high only while the sequencer
// is idle.
// A finished result sits in the output register; the next item is accepted
// while it waits, and that item's result waits in turn until m_tready frees
// the register. Reset empties the store at once (count to zero) and drops any
// pending result; no clearing pass is needed.
module bounded_set_store_core
  import bss_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0 up: element_value[31:0], read_index[39:32].
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0 up: mode[2:0].
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0 up: status[1:0], was_member[2], read_value[34:3],
  // count[43:35], zero padding[47:44].
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state, state_next;

  // Latched operation.
  logic [MODE_W-1:0]  op_mode;
  logic [VALUE_W-1:0] op_value;

  // Store contents and bookkeeping.
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      idx_inc;

  // Result fields under construction.
  logic [STATUS_W-1:0] res_status;
  logic                res_member;
  logic [VALUE_W-1:0]  res_read;

  // Memory port controls.
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic               load_out;

  // Shared compare and step signals.
  logic               hit;
  logic               more;
  logic               is_search;
  logic               in_empty;
  logic [COUNT_W-1:0] in_index_ext;
  logic [COUNT_W-1:0] count_ext;

  assign idx_inc      = idx + CW'(1);
  assign hit          = (rd_data == op_value);
  assign more         = (idx_inc < count);
  assign is_search    = (op_mode == MODE_ADD) || (op_mode == MODE_REMOVE) ||
                        (op_mode == MODE_QUERY);
  assign in_empty     = (count == '0);
  assign in_index_ext = COUNT_W'(s_tdata[IN_DATA_W-1:VALUE_W]);
  assign count_ext    = COUNT_W'(count);

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            MODE_ADD, MODE_REMOVE, MODE_QUERY: begin
              state_next = in_empty ? S_APPLY : S_SCAN_RD;
            end
            MODE_READ: begin
              state_next = in_empty ? S_FINISH : S_READ_RD;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (hit) begin
          if (op_mode == MODE_REMOVE && more) begin
            state_next = S_SHIFT_RD;
          end else begin
            state_next = S_FINISH;
          end
        end else if (more) begin
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_next = more ? S_SHIFT_RD : S_FINISH;
      end
      S_READ_RD: begin
        state_next = S_READ_LOAD;
      end
      S_READ_LOAD: begin
        state_next = S_FINISH;
      end
      S_APPLY: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output and memory-port logic of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    we       = 1'b0;
    waddr    = idx[AW-1:0];
    wdata    = rd_data;
    load_out = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_SHIFT_WR: begin
        // Move the entry just read one place down.
        we    = 1'b1;
        waddr = AW'(idx - CW'(1));
        wdata = rd_data;
      end
      S_APPLY: begin
        // Append a new value when it was absent and there is room.
        we    = (op_mode == MODE_ADD) && (count < CAP_C);
        waddr = count[AW-1:0];
        wdata = op_value;
      end
      S_FINISH: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser == MODE_CLEAR) begin
            count <= '0;
          end
        end
        S_SCAN_CMP: begin
          if (hit && op_mode == MODE_REMOVE && !more) begin
            count <= count - CW'(1);
          end
        end
        S_SHIFT_WR: begin
          if (!more) begin
            count <= count - CW'(1);
          end
        end
        S_APPLY: begin
          if (op_mode == MODE_ADD && count < CAP_C) begin
            count <= count + CW'(1);
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Operation latch, scan index and result fields.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_mode    <= s_tuser;
        op_value   <= s_tdata[VALUE_W-1:0];
        res_status <= ST_OK;
        res_member <= 1'b0;
        res_read   <= '0;
        idx        <= '0;
        if (s_tuser == MODE_READ) begin
          if (in_empty) begin
            res_status <= ST_EMPTY;
          end else if (in_index_ext >= count_ext) begin
            // Past the end reads the last entry.
            idx <= count - CW'(1);
          end else begin
            idx <= CW'(in_index_ext);
          end
        end
      end
      S_SCAN_CMP: begin
        if (hit) begin
          res_member <= 1'b1;
          idx        <= idx_inc;
        end else if (more) begin
          idx <= idx_inc;
        end
      end
      S_SHIFT_WR: begin
        idx <= idx_inc;
      end
      S_READ_LOAD: begin
        res_read <= rd_data;
      end
      S_APPLY: begin
        if (op_mode == MODE_ADD && count >= CAP_C) begin
          res_status <= ST_OVERFLOW;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Output register; it frees as soon as the receiver takes the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{(OUT_DATA_W - COUNT_W - VALUE_W - 1 - STATUS_W){1'b0}},
                  count_ext, res_read, res_member & is_search, res_status};
    end
  end

endmodule
